@@ design/ssd_pkg.sv @@
package ssd_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int POS_WIDTH   = 2;
   localparam int CODE_WIDTH  = 4;
   localparam int WORK_WIDTH  = 14;
   localparam int VALUE_WIDTH = 16;
   localparam int BYTE_WIDTH  = 8;

   localparam logic [CODE_WIDTH-1:0]  BLANK_CODE  = 4'hf;
   localparam logic [VALUE_WIDTH-1:0] MAX_DECIMAL = 16'd9999;

   // v / 10 == (v * 52429) >> 19 for every v below 43690
   localparam logic [15:0] RECIP_TEN   = 16'd52429;
   localparam int          RECIP_SHIFT = 19;
   localparam int          PROD_WIDTH  = WORK_WIDTH + 16;

   typedef enum logic [1:0] {
      OP_SET_VALUE  = 2'd0,
      OP_SET_DIGITS = 2'd1,
      OP_TICK       = 2'd2
   } ssd_op_type;

   typedef enum logic {
      ST_IDLE    = 1'b0,
      ST_CONVERT = 1'b1
   } ssd_state_type;

   typedef struct packed {
      logic load_value;
      logic load_digits;
      logic step;
      logic emit;
   } ssd_cmd_type;

   typedef struct packed {
      logic conv_last;
   } ssd_status_type;

endpackage

@@ design/ssd_datapath.sv @@
module ssd_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  ssd_pkg::ssd_cmd_type   cmd,
   input  logic [15:0]            req_value,
   output ssd_pkg::ssd_status_type status,
   output logic [7:0]             rsp_port_byte
);
   import ssd_pkg::*;

   logic [CODE_WIDTH-1:0]  codes_ff [DIGIT_COUNT];
   logic [WORK_WIDTH-1:0]  work_ff, work_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic [POS_WIDTH-1:0]   scan_ff, scan_in;
   logic [BYTE_WIDTH-1:0]  port_byte_ff, port_byte_in;

   logic [PROD_WIDTH-1:0]  prod;
   logic [WORK_WIDTH-1:0]  quot;
   logic [WORK_WIDTH-1:0]  quot_ten;
   logic [WORK_WIDTH-1:0]  diff;
   logic [CODE_WIDTH-1:0]  rem;
   logic                   value_special;
   logic [DIGIT_COUNT-1:0] scan_enable;

   // one decimal digit per step: reciprocal multiply, then back-subtract
   assign prod     = PROD_WIDTH'(work_ff) * PROD_WIDTH'(RECIP_TEN);
   assign quot     = WORK_WIDTH'(prod >> RECIP_SHIFT);
   assign quot_ten = WORK_WIDTH'({quot, 3'b000}) + WORK_WIDTH'({quot, 1'b0});
   assign diff     = work_ff - quot_ten;
   assign rem      = diff[CODE_WIDTH-1:0];

   assign value_special = (req_value == '0) || (req_value > MAX_DECIMAL);
   assign scan_enable   = DIGIT_COUNT'(1) << scan_ff;

   assign status.conv_last = (work_ff == '0) || (pos_ff == POS_WIDTH'(DIGIT_COUNT - 1))
                             || (quot == '0);

   always_comb begin
      work_in      = work_ff;
      pos_in       = pos_ff;
      scan_in      = scan_ff;
      port_byte_in = port_byte_ff;
      if (cmd.load_value) begin
         work_in = value_special ? '0 : req_value[WORK_WIDTH-1:0];
         pos_in  = '0;
      end else if (cmd.step && work_ff != '0) begin
         work_in = quot;
         pos_in  = pos_ff + 1'b1;
      end
      if (cmd.emit) begin
         port_byte_in = {scan_enable, codes_ff[scan_ff]};
         scan_in      = scan_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff[0] <= 4'd0;
         codes_ff[1] <= 4'd5;
         codes_ff[2] <= BLANK_CODE;
         codes_ff[3] <= BLANK_CODE;
         work_ff     <= '0;
         pos_ff      <= '0;
         scan_ff     <= '0;
      end else begin
         work_ff <= work_in;
         pos_ff  <= pos_in;
         scan_ff <= scan_in;
         if (cmd.load_value) begin
            // blank everything; a zero or out-of-range value shows a lone 0
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               codes_ff[i] <= BLANK_CODE;
            end
            if (value_special) begin
               codes_ff[0] <= 4'd0;
            end
         end else if (cmd.load_digits) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               codes_ff[i] <= req_value[i*CODE_WIDTH +: CODE_WIDTH];
            end
         end else if (cmd.step && work_ff != '0) begin
            codes_ff[pos_ff] <= rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      port_byte_ff <= port_byte_in;
   end

   assign rsp_port_byte = port_byte_ff;

endmodule

@@ design/ssd_ctrl.sv @@
module ssd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_op,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  ssd_pkg::ssd_status_type status,
   output ssd_pkg::ssd_cmd_type   cmd
);
   import ssd_pkg::*;

   ssd_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      // stall every item during conversion; hold a tick while the output register is full and not draining
      req_stall = (state_ff != ST_IDLE)
                  || (rsp_valid_ff && rsp_stall && req_op == OP_TICK);
      accept    = req_valid && !req_stall;

      cmd.load_value  = accept && (req_op == OP_SET_VALUE);
      cmd.load_digits = accept && (req_op == OP_SET_DIGITS);
      cmd.emit        = accept && (req_op == OP_TICK);
      cmd.step        = (state_ff == ST_CONVERT);

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load_value) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (status.conv_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while held");

   a_convert_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT) |-> (req_stall && !cmd.emit && !cmd.load_digits))
      else $error("item accepted during conversion");

   a_load_enters_convert: assert property (@(posedge clock) disable iff (reset)
      cmd.load_value |=> (state_ff == ST_CONVERT))
      else $error("set-value did not start conversion");

   a_emit_raises_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("tick gave no result");

endmodule

@@ design/seven_segment_scan_driver_core.sv @@
// Four-digit multiplexed seven-segment scan driver.
// Input channel (req_valid / req_stall, req_op, req_value) carries one item:
//   set value   - req_value shown in decimal, leading digits blank; zero or
//                 a value above 9999 shows a single 0 on the right.
//   set digits  - req_value holds four codes, bits 15:12 leftmost.
//   tick        - emits the byte for the current scan position, then moves
//                 the position on (0 to 3, wrapping).
// Result channel (rsp_valid / rsp_stall, rsp_port_byte) carries one item per
// tick: one-hot digit enable in the upper nibble, code in the lower (15 blank).
// A tick result is valid the cycle after the tick is accepted. Set digits
// loads the codes directly. Set value loads the value, then runs digit
// extraction (one reciprocal multiply per digit), during which
// req_stall is high.
// A finished result sits in an output register; while the receiver stalls
// it, set operations are still taken, and a further tick is stalled.
// Synchronous reset shows the value 50 and clears the scan position to 0.
module seven_segment_scan_driver_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_port_byte
);
   import ssd_pkg::*;

   ssd_cmd_type    cmd;
   ssd_status_type status;

   ssd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ssd_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_value     (req_value),
      .status        (status),
      .rsp_port_byte (rsp_port_byte)
   );

endmodule

@@ tb/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ssd_pkg::*;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int RANDOM_ITEMS       = 1300;
   localparam int IDLE_LIMIT         = 2000;
   localparam int DRAIN_CYCLES       = 16;
   localparam int DIRECTED_COUNT     = 25;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] value;
      logic        known;
      logic [7:0]  known_byte;
   } display_cmd_type;

   // Reset shows fifty; then zero, the largest value, out-of-range values,
   // packed codes above nine, the unused op and interior zeros.
   localparam display_cmd_type DIRECTED [DIRECTED_COUNT] = '{
      '{OP_TICK,       16'h0000, 1'b1, 8'h10},
      '{OP_TICK,       16'h0000, 1'b1, 8'h25},
      '{OP_TICK,       16'h0000, 1'b1, 8'h4f},
      '{OP_TICK,       16'h0000, 1'b1, 8'h8f},
      '{OP_SET_VALUE,  16'd0,    1'b0, 8'h00},
      '{OP_TICK,       16'h0000, 1'b1, 8'h10},
      '{OP_TICK,       16'h0000, 1'b1, 8'h2f},
      '{OP_TICK,       16'h0000, 1'b1, 8'h4f},
      '{OP_TICK,       16'h0000, 1'b1, 8'h8f},
      '{OP_SET_VALUE,  16'd9999, 1'b0, 8'h00},
      '{OP_TICK,       16'hffff, 1'b1, 8'h19},
      '{OP_TICK,       16'hffff, 1'b1, 8'h29},
      '{OP_TICK,       16'hffff, 1'b1, 8'h49},
      '{OP_TICK,       16'hffff, 1'b1, 8'h89},
      '{OP_SET_VALUE,  16'd10000, 1'b0, 8'h00},
      '{OP_TICK,       16'h0000, 1'b1, 8'h10},
      '{OP_SET_VALUE,  16'hffff, 1'b0, 8'h00},
      '{OP_TICK,       16'h0000, 1'b1, 8'h2f},
      '{OP_SET_DIGITS, 16'habcf, 1'b0, 8'h00},
      '{OP_TICK,       16'h0000, 1'b1, 8'h4b},
      '{OP_TICK,       16'h0000, 1'b1, 8'h8a},
      '{OP_UNUSED,     16'hffff, 1'b0, 8'h00},
      '{OP_TICK,       16'h0000, 1'b1, 8'h1f},
      '{OP_SET_VALUE,  16'd1000, 1'b0, 8'h00},
      '{OP_TICK,       16'h0000, 1'b0, 8'h00}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_SET_VALUE;
   logic [15:0] req_value = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_port_byte;

   seven_segment_scan_driver_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_port_byte (rsp_port_byte)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   display_cmd_type cmd_queue[$];
   display_cmd_type cur_cmd;
   logic [7:0]   expected_bytes[$];
   logic [7:0]   shown_bytes[DIGIT_COUNT];
   logic [1:0]   scan_pos;
   int           next_cmd = 0;
   int           items_taken = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   int           fail_count = 0;
   int           idle_cycles = 0;
   int           phase_count = 0;
   int           mode_left = 0;
   int           stall_mode = 0;

   function automatic logic [7:0] digit_byte(input int pos, input logic [3:0] code);
      logic [3:0] enable;
      enable = 4'b0001 << pos;
      return {enable, code};
   endfunction

   function automatic logic [15:0] pick_decimal();
      case ($urandom_range(0, 7))
         0: return 16'd0;
         1: return 16'($urandom_range(1, 9));
         2: return 16'($urandom_range(10, 99));
         3: return 16'($urandom_range(100, 999));
         4: return 16'($urandom_range(1000, 9999));
         5: return 16'($urandom_range(10000, 65535));
         6: return 16'($urandom_range(9998, 10001));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Track the display for one accepted item and queue what a tick should show.
   task automatic update_display(input display_cmd_type cmd);
      int v;
      int p;
      case (cmd.op)
         OP_SET_VALUE: begin
            for (p = 0; p < DIGIT_COUNT; p++) shown_bytes[p] = digit_byte(p, BLANK_CODE);
            if (cmd.value == 16'd0 || cmd.value > MAX_DECIMAL) begin
               shown_bytes[0] = digit_byte(0, 4'd0);
            end else begin
               v = cmd.value;
               p = 0;
               while (v > 0 && p < DIGIT_COUNT) begin
                  shown_bytes[p] = digit_byte(p, 4'(v % 10));
                  v = v / 10;
                  p++;
               end
            end
         end
         OP_SET_DIGITS: begin
            for (p = 0; p < DIGIT_COUNT; p++) shown_bytes[p] = digit_byte(p, cmd.value[4*p +: 4]);
         end
         OP_TICK: begin
            expected_bytes.push_back(cmd.known ? cmd.known_byte : shown_bytes[scan_pos]);
            scan_pos = scan_pos + 2'd1;
         end
         default: ;
      endcase
   endtask

   initial begin
      int i;
      int pick;
      display_cmd_type cmd;
      // Reset state: fifty on the right, scan at the first digit.
      shown_bytes[0] = 8'h10;
      shown_bytes[1] = 8'h25;
      shown_bytes[2] = 8'h4f;
      shown_bytes[3] = 8'h8f;
      scan_pos = 2'd0;
      for (i = 0; i < DIRECTED_COUNT; i++) cmd_queue.push_back(DIRECTED[i]);
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 99);
         cmd.known = 1'b0;
         cmd.known_byte = 8'h00;
         cmd.value = 16'($urandom_range(0, 65535));
         if (pick < 45) begin
            cmd.op = OP_TICK;
         end else if (pick < 75) begin
            cmd.op = OP_SET_VALUE;
            cmd.value = pick_decimal();
         end else if (pick < 95) begin
            cmd.op = OP_SET_DIGITS;
         end else begin
            cmd.op = OP_UNUSED;
         end
         cmd_queue.push_back(cmd);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      wait (items_taken == cmd_queue.size());
      wait (expected_bytes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS seven_segment_scan_driver_core");
      end else begin
         $display("FAIL seven_segment_scan_driver_core");
      end
      $finish;
   end

   // Sender: bursts of random length with random gaps; hold the item while stalled.
   always @(posedge clock) begin : sender
      logic took;
      took = req_valid && !req_stall;
      if (took) begin
         update_display(cur_cmd);
         items_taken++;
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || took) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (next_cmd < cmd_queue.size()) begin
            cur_cmd = cmd_queue[next_cmd];
            next_cmd++;
            req_op <= cur_cmd.op;
            req_value <= cur_cmd.value;
            req_valid <= 1'b1;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: switch between no stalls, light, heavy and periodic stalling.
   always @(posedge clock) begin
      phase_count <= phase_count + 1;
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left <= $urandom_range(32, 256);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= (phase_count % 7) < 3;
      endcase
   end

   always @(posedge clock) begin : result_check
      logic [7:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $error("unexpected port_byte %02h with nothing outstanding", rsp_port_byte);
            fail_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_port_byte !== want) begin
               $error("port_byte mismatch: expected %02h, got %02h", want, rsp_port_byte);
               fail_count++;
            end
         end
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("FAIL seven_segment_scan_driver_core");
      $finish;
   end

endmodule
